// ===== design/ced_pkg.sv =====
package ced_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch7     = 8'h37;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLoF   = 8'h66;

  // one decoded input: up to four output words, term marks the last as terminator
  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
    logic            term;
  } cmd_t;

endpackage

// ===== design/ced_front.sv =====
module ced_front import ced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    PhNormal,
    PhEscape,
    PhHex,
    PhOctal
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] cnt_q, cnt_d;
  logic [8:0] val_q, val_d;

  logic [7:0] b;
  logic       is_oct, is_hex;
  logic [3:0] hex_d;
  logic       nb_emit;
  logic       nb_term;
  phase_e     nb_phase;
  logic [8:0] hex_val, oct_val;
  cmd_t       cmd;

  assign b = in_byte_i;
  assign is_oct = (b >= Ch0) && (b <= Ch7);

  always_comb begin
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if ((b >= Ch0) && (b <= Ch9)) begin
      hex_d = b[3:0];
    end else if (((b >= ChUpA) && (b <= ChUpF)) || ((b >= ChA) && (b <= ChLoF))) begin
      hex_d = b[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // byte handled as plain text
  assign nb_term  = (b == ChNul);
  assign nb_emit  = (b != ChBsl);
  assign nb_phase = (b == ChBsl) ? PhEscape : PhNormal;

  assign hex_val = {val_q[4:0], hex_d};
  assign oct_val = {val_q[5:0], b[2:0]};

  always_comb begin
    cmd     = '0;
    phase_d = PhNormal;
    cnt_d   = 2'd0;
    val_d   = 9'd0;
    case (phase_q)
      PhNormal: begin
        phase_d      = nb_phase;
        cmd.bytes[0] = b;
        cmd.n        = {2'b00, nb_emit};
        cmd.term     = nb_term;
      end
      PhEscape: begin
        cmd.n = 3'd1;
        case (b)
          ChN:     cmd.bytes[0] = 8'd10;
          ChT:     cmd.bytes[0] = 8'd9;
          ChV:     cmd.bytes[0] = 8'd11;
          ChB:     cmd.bytes[0] = 8'd8;
          ChR:     cmd.bytes[0] = 8'd13;
          ChF:     cmd.bytes[0] = 8'd12;
          ChA:     cmd.bytes[0] = 8'd7;
          ChBsl, ChQmark, ChSq, ChDq: cmd.bytes[0] = b;
          ChX: begin
            cmd.n   = 3'd0;
            phase_d = PhHex;
          end
          default: begin
            if (is_oct) begin
              cmd.n   = 3'd0;
              phase_d = PhOctal;
              cnt_d   = 2'd1;
              val_d   = {6'd0, b[2:0]};
            end else begin
              // unknown escape: backslash, then the byte as plain text
              cmd.bytes[0] = ChBsl;
              cmd.bytes[1] = b;
              cmd.n        = 3'd1 + {2'b00, nb_emit};
              cmd.term     = nb_term;
              phase_d      = nb_phase;
            end
          end
        endcase
      end
      PhHex: begin
        if (is_hex) begin
          if (cnt_q != 2'd0) begin
            cmd.n        = 3'd1;
            cmd.bytes[0] = hex_val[7:0];
          end else begin
            phase_d = PhHex;
            cnt_d   = 2'd1;
            val_d   = hex_val;
          end
        end else if (cnt_q == 2'd0) begin
          // bare \x
          cmd.bytes[0] = ChBsl;
          cmd.bytes[1] = ChX;
          cmd.bytes[2] = b;
          cmd.n        = 3'd2 + {2'b00, nb_emit};
          cmd.term     = nb_term;
          phase_d      = nb_phase;
        end else begin
          cmd.bytes[0] = val_q[7:0];
          cmd.bytes[1] = b;
          cmd.n        = 3'd1 + {2'b00, nb_emit};
          cmd.term     = nb_term;
          phase_d      = nb_phase;
        end
      end
      PhOctal: begin
        if (is_oct) begin
          if (cnt_q == 2'd2) begin
            if (oct_val[8]) begin
              cmd.n        = 3'd4;
              cmd.bytes[0] = ChBsl;
              cmd.bytes[1] = {5'b00110, oct_val[8:6]};
              cmd.bytes[2] = {5'b00110, oct_val[5:3]};
              cmd.bytes[3] = {5'b00110, oct_val[2:0]};
            end else begin
              cmd.n        = 3'd1;
              cmd.bytes[0] = oct_val[7:0];
            end
          end else begin
            phase_d = PhOctal;
            cnt_d   = cnt_q + 2'd1;
            val_d   = oct_val;
          end
        end else begin
          cmd.bytes[0] = val_q[7:0];
          cmd.bytes[1] = b;
          cmd.n        = 3'd1 + {2'b00, nb_emit};
          cmd.term     = nb_term;
          phase_d      = nb_phase;
        end
      end
      default: ;
    endcase
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept_i && (cmd.n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      cnt_q   <= 2'd0;
      val_q   <= 9'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      val_q   <= val_d;
    end
  end

endmodule

// ===== design/ced_fifo.sv =====
module ced_fifo import ced_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/ced_back.sv =====
module ced_back import ced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, end_q;
  logic       load, is_last;

  assign load      = !cmd_empty_i && (!valid_q || pop_i);
  assign is_last   = (({1'b0, idx_q} + 3'd1) == cmd_i.n);
  assign cmd_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cmd_i.bytes[idx_q];
      last_q <= is_last;
      end_q  <= is_last && cmd_i.term;
    end
  end

  assign empty_o      = !valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = last_q;
  assign string_end_o = end_q;

endmodule

// ===== design/c_escape_sequence_decoder.sv =====
// Decodes C escape sequences in a byte stream; a zero byte ends the string and comes out
// with string_end set. One input word is taken every cycle while full is low: the decoder
// front classifies it combinationally and queues the words it causes (0 to 4) in a
// four-entry command queue. The back end delivers one result word per cycle from an output
// register while pop is high, so the sustained rate is one input per cycle as long as each
// input yields at most one word; longer bursts (unknown escapes, bare \x, octal above 255,
// cut-short hex or octal) drain one word per cycle, can fill the queue and so raise full.
module c_escape_sequence_decoder import ced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  logic accept;
  logic cmd_push, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  assign accept = push && !full;

  ced_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  ced_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  ced_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_out),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule
